[sv/pe_pkg.sv]
// ----------------------------------------------------------------------------
// pe_pkg
// Shared types and constants of the polynomial evaluator: Q16.16 word format,
// coefficient register count and the control token that travels through the
// Horner pipeline.
// ----------------------------------------------------------------------------
package pe_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int REG_COUNT = 8;
	localparam int IDX_W     = 3;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SHIFT_W   = PROD_W - FRAC_W;
	localparam int SUM_W     = SHIFT_W + 1;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [IDX_W-1:0] reg_idx_t;

	// Control token carried alongside each item in the pipeline.
	typedef struct packed {
		logic valid;
		logic sat;
	} ctl_t;

endpackage

[sv/pe_ifs.sv]
// ----------------------------------------------------------------------------
// Polynomial evaluator channels
// Valid/ready channels for evaluation points, results and coefficient writes.
// ----------------------------------------------------------------------------
interface pe_point_if;
	logic          valid;
	logic          ready;
	pe_pkg::word_t point;

	modport source (output valid, output point, input ready);
	modport sink (input valid, input point, output ready);
endinterface

interface pe_result_if;
	logic          valid;
	logic          ready;
	pe_pkg::word_t poly_value;
	logic          saturated;

	modport source (output valid, output poly_value, output saturated, input ready);
	modport sink (input valid, input poly_value, input saturated, output ready);
endinterface

interface pe_cfg_if;
	logic             valid;
	logic             ready;
	pe_pkg::reg_idx_t index;
	pe_pkg::word_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[sv/polynomial_evaluator.sv]
// ----------------------------------------------------------------------------
// polynomial_evaluator
// Streams signed Q16.16 points through a pipelined Horner evaluation of a
// polynomial with up to eight programmable coefficients.
// ----------------------------------------------------------------------------
// Usage:
// Coefficients coef_0 .. coef_7 are written through the cfg channel, one
// register per beat, with index selecting the power of x. The cfg channel is
// always ready. Write them while no point is in flight; unused high
// coefficients left at zero lower the effective degree.
// Each beat on the sample channel carries one point x; each beat on the
// result channel carries p(x) in Q16.16 and a flag that is set when any
// Horner addition clamped to the signed 32-bit range.
// Every Horner step takes two register stages: the first holds the 32x32
// product, the second the shifted product plus coefficient after clamping.
// One point is accepted every cycle unless the pipeline is full and stalled.
// When the receiver stalls, the last stage holds its result and the stages
// behind it keep filling any empty slots, so sample.ready drops only once
// the whole pipeline is full. Reset clears all coefficients to zero and
// empties the pipeline.
// ----------------------------------------------------------------------------
module polynomial_evaluator #(
	parameter int NUM_COEFFS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	pe_point_if.sink    sample,
	pe_result_if.source result,
	pe_cfg_if.sink      cfg
);

	// One Horner step per coefficient below the leading one.
	localparam int NSTEP = NUM_COEFFS - 1;

	pe_pkg::word_t coefs [pe_pkg::REG_COUNT];
	pe_pkg::ctl_t  ctl_c [NSTEP+1];
	pe_pkg::word_t acc_c [NSTEP+1];
	pe_pkg::word_t x_c   [NSTEP+1];
	logic          en_c  [NSTEP+1];

	pe_coef_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coefs  (coefs)
	);

	// The accumulator starts at the leading coefficient; the point rides along.
	assign ctl_c[0] = '{valid: sample.valid, sat: 1'b0};
	assign acc_c[0] = coefs[NUM_COEFFS-1];
	assign x_c[0]   = sample.point;
	assign sample.ready = en_c[0];

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		pe_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en_dn   (en_c[k+1]),
			.en_up   (en_c[k]),
			.ctl_in  (ctl_c[k]),
			.acc_in  (acc_c[k]),
			.x_in    (x_c[k]),
			.coef    (coefs[NUM_COEFFS-2-k]),
			.ctl_out (ctl_c[k+1]),
			.acc_out (acc_c[k+1]),
			.x_out   (x_c[k+1])
		);
	end

	// The last stage register doubles as the output register.
	assign en_c[NSTEP]       = result.ready;
	assign result.valid      = ctl_c[NSTEP].valid;
	assign result.poly_value = acc_c[NSTEP];
	assign result.saturated  = ctl_c[NSTEP].sat;

endmodule

[sv/pe_coef_regs.sv]
// ----------------------------------------------------------------------------
// pe_coef_regs
// Coefficient register file: eight signed Q16.16 registers written through
// the configuration channel, cleared by reset.
// ----------------------------------------------------------------------------
module pe_coef_regs (
	input  logic          clk,
	input  logic          arst_n,
	pe_cfg_if.sink        cfg,
	output pe_pkg::word_t coefs [pe_pkg::REG_COUNT]
);

	pe_pkg::word_t coef_q [pe_pkg::REG_COUNT];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pe_pkg::REG_COUNT; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			coef_q[cfg.index] <= cfg.data;
		end
	end

	assign coefs = coef_q;

endmodule

[sv/pe_step.sv]
// ----------------------------------------------------------------------------
// pe_step
// One Horner step in two stages: a registered 32x32 product, then a floor
// shift by the fraction width, the coefficient add and saturation.
// ----------------------------------------------------------------------------
module pe_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en_dn,
	output logic          en_up,
	input  pe_pkg::ctl_t  ctl_in,
	input  pe_pkg::word_t acc_in,
	input  pe_pkg::word_t x_in,
	input  pe_pkg::word_t coef,
	output pe_pkg::ctl_t  ctl_out,
	output pe_pkg::word_t acc_out,
	output pe_pkg::word_t x_out
);

	localparam int HEAD_W = pe_pkg::SUM_W - pe_pkg::DATA_W + 1;

	pe_pkg::ctl_t                       ctl_s1, ctl_s2;
	logic signed [pe_pkg::PROD_W-1:0]  prod_s1;
	pe_pkg::word_t                      x_s1, x_s2, acc_s2;
	logic                               en_s1, en_s2;
	logic signed [pe_pkg::SHIFT_W-1:0] shifted;
	logic signed [pe_pkg::SUM_W-1:0]   sum;
	logic [HEAD_W-1:0]                  head;
	logic                               ovf;
	pe_pkg::word_t                      clamped;

	// A stage loads when it is empty or its successor moves.
	assign en_s2 = !ctl_s2.valid || en_dn;
	assign en_s1 = !ctl_s1.valid || en_s2;
	assign en_up = en_s1;

	// Arithmetic shift of the product is a floor division by 2^16.
	assign shifted = prod_s1[pe_pkg::PROD_W-1:pe_pkg::FRAC_W];
	assign sum     = {shifted[pe_pkg::SHIFT_W-1], shifted}
	               + {{(pe_pkg::SUM_W-pe_pkg::DATA_W){coef[pe_pkg::DATA_W-1]}}, coef};
	assign head    = sum[pe_pkg::SUM_W-1:pe_pkg::DATA_W-1];
	assign ovf     = !((&head) || !(|head));

	always_comb begin
		if (!ovf) begin
			clamped = sum[pe_pkg::DATA_W-1:0];
		end else if (sum[pe_pkg::SUM_W-1]) begin
			clamped = {1'b1, {(pe_pkg::DATA_W-1){1'b0}}};
		end else begin
			clamped = {1'b0, {(pe_pkg::DATA_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			if (en_s1) begin
				ctl_s1 <= ctl_in;
			end
			if (en_s2) begin
				ctl_s2.valid <= ctl_s1.valid;
				ctl_s2.sat   <= ctl_s1.sat | ovf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= pe_pkg::PROD_W'(acc_in) * pe_pkg::PROD_W'(x_in);
			x_s1    <= x_in;
		end
		if (en_s2) begin
			acc_s2 <= clamped;
			x_s2   <= x_s1;
		end
	end

	assign ctl_out = ctl_s2;
	assign acc_out = acc_s2;
	assign x_out   = x_s2;

endmodule

[sv/pe_checker.sv]
// ----------------------------------------------------------------------------
// pe_checker
// Port-level checks of the polynomial evaluator: result hold under stall and
// occupancy bounds of the pipeline.
// ----------------------------------------------------------------------------
module pe_checker #(
	parameter int NUM_COEFFS = 8
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input pe_pkg::word_t out_value,
	input logic          out_sat
);

	localparam int CAP   = 2 * (NUM_COEFFS - 1);
	localparam int CNT_W = $clog2(CAP + 1);

	logic [CNT_W-1:0] inflight_q;
	logic             in_beat, out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_beat && !out_beat) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (out_beat && !in_beat) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_sat))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result without an accepted point");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(CAP))
		else $error("more points in flight than pipeline stages");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == CNT_W'(CAP) && !out_beat |-> !in_ready)
		else $error("point accepted into a full pipeline");

endmodule

bind polynomial_evaluator pe_checker #(.NUM_COEFFS(NUM_COEFFS)) u_pe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_value (result.poly_value),
	.out_sat   (result.saturated)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: polynomial evaluator testbench
// Writes coefficient sets through the cfg channel while the pipeline is
// empty, streams evaluation points and checks every result beat against a
// hand-computed value or a Horner predictor that tracks the coefficient
// writes. A short table of directed rows runs first, followed by randomized
// phases with random source gaps, sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb;

	localparam int NUM_COEFFS     = 8;
	localparam int LATENCY        = 2 * (NUM_COEFFS - 1);
	localparam int RAND_PHASES    = 10;
	localparam int RAND_PER_PHASE = 50;
	localparam int MAX_GAP        = 6;
	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 50;
	localparam int DIR_ROWS       = 32;

	// Q16.16 landmarks.
	localparam pe_pkg::word_t W_MAX      = 32'sh7FFF_FFFF;
	localparam pe_pkg::word_t W_MIN      = 32'sh8000_0000;
	localparam pe_pkg::word_t Q_ONE      = 32'sh0001_0000;
	localparam pe_pkg::word_t Q_NEG_ONE  = 32'shFFFF_0000;
	localparam pe_pkg::word_t Q_LSB      = 32'sh0000_0001;
	localparam pe_pkg::word_t Q_NEG_LSB  = 32'shFFFF_FFFF;
	localparam pe_pkg::word_t POINT_SPAN = 32'sh0002_0000;
	localparam pe_pkg::word_t COEF_SPAN  = 32'sh0004_0000;

	typedef enum logic [pe_pkg::IDX_W-1:0] {
		COEF_0, COEF_1, COEF_2, COEF_3, COEF_4, COEF_5, COEF_6, COEF_7
	} coef_idx_e;

	typedef enum logic [1:0] {ROW_WRITE, ROW_FILL, ROW_POINT} row_kind_e;

	typedef enum logic [1:0] {STYLE_FULL, STYLE_SMALL, STYLE_BOUNDARY} coef_style_e;

	// One directed row: a single register write, a write of the same value to
	// every register, or a point with an optional hand-computed result.
	typedef struct packed {
		row_kind_e     kind;
		coef_idx_e     idx;
		pe_pkg::word_t value;
		logic          typed;
		pe_pkg::word_t exp_value;
		logic          exp_sat;
	} stim_row_t;

	typedef struct packed {
		pe_pkg::word_t value;
		logic          sat;
	} horner_result_t;

	logic clk;
	logic arst_n;

	pe_point_if  sample_ch ();
	pe_result_if result_ch ();
	pe_cfg_if    cfg_ch ();

	polynomial_evaluator #(
		.NUM_COEFFS(NUM_COEFFS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	// Coefficients as the block holds them, updated on each cfg beat.
	pe_pkg::word_t coef_model [pe_pkg::REG_COUNT];
	// Results still owed by the block, oldest first.
	horner_result_t pending_values [$];
	int mismatch_count;

	// Traffic shaping; calm is shared between source and sink, hold_req is for the sink only.
	logic calm;
	logic hold_req;

	logic point_open;
	logic cfg_open;

	stim_row_t dir_tab [DIR_ROWS];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Horner's rule over the used coefficients. Each product is exact in
	// 64 bits, the arithmetic shift floors it, and every sum is clamped to
	// the 32-bit range before the next step.
	function automatic horner_result_t horner_eval(input pe_pkg::word_t x);
		logic signed [63:0] acc;
		logic signed [63:0] prod;
		logic signed [63:0] sum;
		horner_result_t     res;
		int                 i;
		acc     = 64'(coef_model[NUM_COEFFS-1]);
		res.sat = 1'b0;
		for (i = NUM_COEFFS - 2; i >= 0; i--) begin
			prod = acc * 64'(x);
			sum  = (prod >>> pe_pkg::FRAC_W) + 64'(coef_model[i]);
			if (sum > 64'(W_MAX)) begin
				sum     = 64'(W_MAX);
				res.sat = 1'b1;
			end else if (sum < 64'(W_MIN)) begin
				sum     = 64'(W_MIN);
				res.sat = 1'b1;
			end
			acc = sum;
		end
		res.value = acc[pe_pkg::DATA_W-1:0];
		return res;
	endfunction

	function automatic stim_row_t wr(input coef_idx_e idx, input pe_pkg::word_t value);
		return '{ROW_WRITE, idx, value, 1'b0, '0, 1'b0};
	endfunction

	function automatic stim_row_t fill(input pe_pkg::word_t value);
		return '{ROW_FILL, COEF_0, value, 1'b0, '0, 1'b0};
	endfunction

	function automatic stim_row_t pt(input pe_pkg::word_t x);
		return '{ROW_POINT, COEF_0, x, 1'b0, '0, 1'b0};
	endfunction

	function automatic stim_row_t ptx(input pe_pkg::word_t x, input pe_pkg::word_t v,
			input logic s);
		return '{ROW_POINT, COEF_0, x, 1'b1, v, s};
	endfunction

	function automatic pe_pkg::word_t boundary_value();
		case ($urandom_range(0, 5))
			0: return W_MAX;
			1: return W_MIN;
			2: return Q_ONE;
			3: return Q_NEG_ONE;
			4: return Q_NEG_LSB;
			default: return '0;
		endcase
	endfunction

	function automatic pe_pkg::word_t rand_coef(input coef_style_e style);
		case (style)
			STYLE_SMALL: return pe_pkg::word_t'($urandom_range(0, 2 * COEF_SPAN))
				- COEF_SPAN;
			STYLE_BOUNDARY: return ($urandom_range(0, 1) != 0) ? boundary_value()
				: pe_pkg::word_t'($urandom());
			default: return pe_pkg::word_t'($urandom());
		endcase
	endfunction

	// Mostly points near the origin, where the polynomial stays in range and
	// the fractional bits matter; the rest spans the whole word.
	function automatic pe_pkg::word_t rand_point();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return pe_pkg::word_t'($urandom_range(0, 2 * POINT_SPAN)) - POINT_SPAN;
		else if (pick < 85)
			return pe_pkg::word_t'($urandom());
		else
			return boundary_value();
	endfunction

	// A write leaves cfg valid high so that back-to-back writes never lower
	// and raise it in the same step; the next point offer lowers it.
	task automatic write_coef(input coef_idx_e idx, input pe_pkg::word_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		cfg_open = 1'b1;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		coef_model[idx] = value;
	endtask

	// Stop offering points and wait until every result has been taken, so
	// that the following register writes land on an empty pipeline.
	task automatic settle_pipeline();
		if (point_open) begin
			sample_ch.valid <= 1'b0;
			point_open = 1'b0;
		end
		while (pending_values.size() != 0)
			@(posedge clk);
	endtask

	task automatic offer_point(input pe_pkg::word_t x, input logic typed,
			input pe_pkg::word_t tv, input logic ts);
		horner_result_t res;
		if (cfg_open) begin
			cfg_ch.valid <= 1'b0;
			cfg_open = 1'b0;
		end
		if (!calm && $urandom_range(0, 99) < 10) begin
			sample_ch.valid <= 1'b0;
			point_open = 1'b0;
			repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.point <= x;
		point_open = 1'b1;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		if (typed) begin
			res.value = tv;
			res.sat   = ts;
		end else begin
			res = horner_eval(x);
		end
		pending_values = {pending_values, res};
	endtask

	// Main sequence: reset, directed table, randomized phases, drain.
	initial begin : stimulus
		stim_row_t   row;
		coef_style_e style;
		int          r;
		int          i;
		int          ph;
		int          n;
		int          deg;
		arst_n          <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.point <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= COEF_0;
		cfg_ch.data     <= '0;
		calm            <= 1'b0;
		hold_req        <= 1'b0;
		point_open      = 1'b0;
		cfg_open        = 1'b0;
		mismatch_count  = 0;
		for (i = 0; i < pe_pkg::REG_COUNT; i++)
			coef_model[i] = '0;

		dir_tab = '{
			// Straight out of reset every coefficient is zero.
			ptx('0, '0, 1'b0), ptx(W_MAX, '0, 1'b0), ptx(W_MIN, '0, 1'b0),
			// Constant polynomial.
			wr(COEF_0, 32'sh0005_0000), ptx(32'sh0001_8000, 32'sh0005_0000, 1'b0),
			// Identity: p(x) = x passes both extremes and the smallest step.
			wr(COEF_1, Q_ONE), wr(COEF_0, '0),
			ptx(W_MAX, W_MAX, 1'b0), ptx(W_MIN, W_MIN, 1'b0),
			ptx(Q_NEG_LSB, Q_NEG_LSB, 1'b0),
			// Clamp at the top, and a sum that just stays in range.
			wr(COEF_0, W_MAX), ptx(Q_ONE, W_MAX, 1'b1), ptx(W_MIN, Q_NEG_LSB, 1'b0),
			// Clamp at the bottom.
			wr(COEF_0, W_MIN), ptx(Q_NEG_ONE, W_MIN, 1'b1), ptx(W_MAX, Q_NEG_LSB, 1'b0),
			// Truncation goes toward minus infinity: -2^-32 floors to -2^-16.
			wr(COEF_1, Q_LSB), wr(COEF_0, '0),
			ptx(Q_NEG_LSB, Q_NEG_LSB, 1'b0), pt(32'sh0000_FFFF),
			// Full degree with every coefficient at the top of its range.
			fill(W_MAX), pt(W_MAX), pt(W_MIN), ptx('0, W_MAX, 1'b0),
			// Full degree at the bottom of the range.
			fill(W_MIN), pt(W_MAX), pt(W_MIN), ptx(Q_ONE, W_MIN, 1'b1),
			// All ones: 8.0 at x = 1 and an alternating sum at x = -1.
			fill(Q_ONE), ptx(Q_ONE, 32'sh0008_0000, 1'b0), ptx(Q_NEG_ONE, '0, 1'b0),
			pt(32'sh0000_8000)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < DIR_ROWS; r++) begin
			row = dir_tab[r];
			case (row.kind)
				ROW_WRITE: begin
					settle_pipeline();
					write_coef(row.idx, row.value);
				end
				ROW_FILL: begin
					settle_pipeline();
					for (i = 0; i < NUM_COEFFS; i++)
						write_coef(coef_idx_e'(i), row.value);
				end
				default: begin
					offer_point(row.value, row.typed, row.exp_value, row.exp_sat);
				end
			endcase
		end

		// Random phases. Each one loads a fresh coefficient set whose degree
		// is chosen at random; the high coefficients above it are zeroed.
		// Two phases run without any idling, and a later phase starts the long
		// sink hold-off so that the pipeline fills and stalls the source.
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			settle_pipeline();
			calm     <= (ph == 2 || ph == 3);
			hold_req <= (ph == 6);
			style = coef_style_e'($urandom_range(0, 2));
			deg   = $urandom_range(0, NUM_COEFFS - 1);
			for (i = 0; i < NUM_COEFFS; i++)
				write_coef(coef_idx_e'(i),
					(i <= deg) ? rand_coef(style) : pe_pkg::word_t'(0));
			for (n = 0; n < RAND_PER_PHASE; n++)
				offer_point(rand_point(), 1'b0, '0, 1'b0);
		end

		settle_pipeline();
		// Any stray beat after the last expected one would show up here.
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Sink: ready drops at random with a probability of one in ten, never while
	// calm, and once for a long counted hold-off when the stimulus asks for it.
	initial begin : result_sink
		logic hold_done;
		hold_done = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			result_ch.ready <= calm || ($urandom_range(0, 99) >= 10);
		end
	end

	// Each result beat is matched against the oldest pending expectation.
	always @(posedge clk) begin : result_check
		horner_result_t want;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_values.size() == 0) begin
				flag_mismatch($sformatf("unexpected result beat value=%h sat=%b",
					result_ch.poly_value, result_ch.saturated));
			end else begin
				want = pending_values.pop_front();
				if (result_ch.poly_value !== want.value)
					flag_mismatch($sformatf("poly_value %h, expected %h",
						result_ch.poly_value, want.value));
				if (result_ch.saturated !== want.sat)
					flag_mismatch($sformatf("saturated %b, expected %b",
						result_ch.saturated, want.sat));
			end
		end
	end

	// Watchdog: a run of cycles without a beat on any channel means the
	// block has hung.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
					(result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
					(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
sv/pe_pkg.sv
sv/pe_ifs.sv
sv/pe_coef_regs.sv
sv/pe_step.sv
sv/polynomial_evaluator.sv
sv/pe_checker.sv
tb/tb.sv
